[sv/probe_point_capture_controller_unit_defines.svh]
// assertion macros shared by the probe point capture controller rtl
`ifndef PROBE_POINT_CAPTURE_CONTROLLER_UNIT_DEFINES_SVH
`define PROBE_POINT_CAPTURE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PPCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PPCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ppcc_pkg.sv]
// types and constants of the probe point capture controller
package ppcc_pkg;

  // position format
  localparam int COORD_BITS = 20;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int D2_W       = 64;

  // configuration register widths
  localparam int PLANE_W    = 2;
  localparam int MIN_DIST_W = 20;
  localparam int THR_W      = 2 * MIN_DIST_W;
  localparam int DEBOUNCE_W = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // record buffer depth
  localparam int MAX_REC   = 5;
  localparam int REC_CNT_W = $clog2(MAX_REC + 1);
  localparam int NUM_BTN   = 3;

  // register indexes
  localparam logic [1:0] REG_TRACE_PLANE = 2'd0;
  localparam logic [1:0] REG_MIN_DIST    = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE    = 2'd2;

  // plane codes, the spare code traces in xy
  localparam logic [PLANE_W-1:0] PLANE_XY    = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_XZ    = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_YZ    = 2'd2;
  localparam logic [PLANE_W-1:0] PLANE_SPARE = 2'd3;

  // register reset values
  localparam logic [PLANE_W-1:0]    PLANE_RST    = PLANE_XZ;
  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 20'd100;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;

  // button slots
  localparam int BTN_SAMPLE = 0;
  localparam int BTN_MODE   = 1;
  localparam int BTN_FOOT   = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_CLEAR  = 2'd3
  } host_cmd_t;

  typedef enum logic [2:0] {
    KIND_POINT          = 3'd0,
    KIND_TRACE_POINT    = 3'd1,
    KIND_TRACE_START    = 3'd2,
    KIND_TRACE_STOP     = 3'd3,
    KIND_MODE_CHANGE    = 3'd4,
    KIND_COUNTERS_RESET = 3'd5
  } rec_kind_t;

  typedef enum logic [1:0] {
    MODE_MEASURE  = 2'd0,
    MODE_TRACING  = 2'd1,
    MODE_DIGITIZE = 2'd2
  } mode_t;

  // one input request
  typedef struct packed {
    host_cmd_t   host_cmd;
    coord_t      pos_x;
    coord_t      pos_y;
    coord_t      pos_z;
    logic        sample_level;
    logic        mode_level;
    logic        foot_level;
    logic [31:0] now_ms;
  } item_t;

  // one capture record
  typedef struct packed {
    rec_kind_t   record_kind;
    logic [31:0] record_index;
    coord_t      coord_a;
    coord_t      coord_b;
    coord_t      coord_c;
    logic [1:0]  current_mode;
    logic        last_of_tick;
  } rec_t;

endpackage

[sv/probe_point_capture_controller_unit.sv]
// probe point capture controller: input register, tick logic, record buffer
//
//   channel | ports                        | carries
//   --------+------------------------------+--------------------------------
//   input   | in_valid in_ready in_data    | item_t, one tick per request
//   output  | out_valid out_ready out_data | rec_t, one capture record
//   config  | psel penable pwrite paddr .. | trace_plane, min distance, debounce
//
// a tick sits in the input register, then all its records (0 to 5) are built
// combinationally and loaded into a 5-entry record buffer that drains one per cycle
// while out_ready is high. a tick with at most one record sustains one request per
// cycle while out_ready is high; a tick with n records holds the buffer until its
// last record is being taken. reset is synchronous, with no clearing pass. a config
// write of min distance lands in min_dist_r and is then squared into thr_sq_r.
`include "probe_point_capture_controller_unit_defines.svh"

module probe_point_capture_controller_unit
  import ppcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  item_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rec_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // squared difference, exact in 42 bits and zero-extended to 64 bits
  function automatic logic [D2_W-1:0] sq_diff(coord_t a, coord_t b);
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic [SQ_W-1:0]          p;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    p = m * m;
    return D2_W'(p);
  endfunction

  // saturating 64-bit add
  function automatic logic [D2_W-1:0] sat_add(logic [D2_W-1:0] a, logic [D2_W-1:0] b);
    logic [D2_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[D2_W] ? {D2_W{1'b1}} : s[D2_W-1:0];
  endfunction

  // configuration registers
  logic [PLANE_W-1:0]    plane_r;
  logic [MIN_DIST_W-1:0] min_dist_r;
  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [THR_W-1:0]      thr_sq_r;
  logic                  cfg_wr;

  // tick state
  mode_t                 mode_r, mode_nxt;
  logic                  tracing_r, tracing_nxt;
  logic [31:0]           pcount_r, pcount_nxt;
  logic [31:0]           tcount_r, tcount_nxt;
  coord_t                lpos_r [3];
  coord_t                lpos_nxt [3];
  logic                  btn_prev_r [NUM_BTN];
  logic                  btn_prev_nxt [NUM_BTN];
  logic [31:0]           press_r [NUM_BTN];
  logic [31:0]           press_nxt [NUM_BTN];

  // input register and record buffer
  logic                  in_vld_r;
  item_t                 in_r;
  rec_t                  rec_r [MAX_REC];
  logic [REC_CNT_W-1:0]  rem_r;
  logic                  buf_free;
  logic                  fire;
  logic                  pop;
  rec_t                  batch [MAX_REC];
  logic [REC_CNT_W-1:0]  n_rec;

  // check terms
  logic                  chk_last_slot;
  logic                  chk_plain_kind;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r    <= PLANE_RST;
      min_dist_r <= MIN_DIST_RST;
      debounce_r <= DEBOUNCE_RST;
      thr_sq_r   <= THR_W'(MIN_DIST_RST * MIN_DIST_RST);
    end else begin
      thr_sq_r <= min_dist_r * min_dist_r;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_TRACE_PLANE: plane_r    <= pwdata[PLANE_W-1:0];
          REG_MIN_DIST:    min_dist_r <= pwdata[MIN_DIST_W-1:0];
          REG_DEBOUNCE:    debounce_r <= pwdata[DEBOUNCE_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  // register read
  always_comb begin
    unique case (paddr[3:2])
      REG_TRACE_PLANE: prdata = CFG_DATA_W'(plane_r);
      REG_MIN_DIST:    prdata = CFG_DATA_W'(min_dist_r);
      REG_DEBOUNCE:    prdata = CFG_DATA_W'(debounce_r);
      default:         prdata = '0;
    endcase
  end

  // handshake: buffer can take a batch when drained or draining its last record
  assign out_valid = (rem_r != '0);
  assign out_data  = rec_r[0];
  assign pop       = out_valid & out_ready;
  assign buf_free  = (rem_r == '0) || ((rem_r == REC_CNT_W'(1)) && out_ready);
  assign fire      = in_vld_r & buf_free;
  assign in_ready  = ~in_vld_r | buf_free;

  // tick logic: build the records and the next state
  always_comb begin
    coord_t          tip [3];
    logic [D2_W-1:0] d2;
    logic            trace_hit;
    logic            hit [NUM_BTN];
    rec_t            cand [MAX_REC];
    logic            cand_v [MAX_REC];
    logic [31:0]     pc;
    logic [31:0]     tc;
    logic            tr;
    mode_t           md;

    tip[0] = in_r.pos_x;
    tip[1] = in_r.pos_y;
    tip[2] = in_r.pos_z;
    for (int i = 0; i < MAX_REC; i++) begin
      cand[i]   = '0;
      cand_v[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) lpos_nxt[i] = lpos_r[i];

    // debounced falling edges
    for (int i = 0; i < NUM_BTN; i++) begin
      btn_prev_nxt[i] = btn_prev_r[i];
      press_nxt[i]    = press_r[i];
    end
    hit[BTN_SAMPLE] = ~in_r.sample_level & btn_prev_r[BTN_SAMPLE] &
                      ((in_r.now_ms - press_r[BTN_SAMPLE]) > 32'(debounce_r));
    hit[BTN_MODE]   = ~in_r.mode_level & btn_prev_r[BTN_MODE] &
                      ((in_r.now_ms - press_r[BTN_MODE]) > 32'(debounce_r));
    hit[BTN_FOOT]   = ~in_r.foot_level & btn_prev_r[BTN_FOOT] &
                      ((in_r.now_ms - press_r[BTN_FOOT]) > 32'(debounce_r));
    btn_prev_nxt[BTN_SAMPLE] = in_r.sample_level;
    btn_prev_nxt[BTN_MODE]   = in_r.mode_level;
    btn_prev_nxt[BTN_FOOT]   = in_r.foot_level;
    for (int i = 0; i < NUM_BTN; i++) begin
      if (hit[i]) press_nxt[i] = in_r.now_ms;
    end

    pc = pcount_r;
    tc = tcount_r;
    tr = tracing_r;
    md = mode_r;

    // trace point
    d2 = sat_add(sat_add(sq_diff(tip[0], lpos_r[0]), sq_diff(tip[1], lpos_r[1])),
                 sq_diff(tip[2], lpos_r[2]));
    trace_hit = tracing_r && (d2 >= D2_W'(thr_sq_r));
    cand_v[0] = trace_hit;
    cand[0].record_kind  = KIND_TRACE_POINT;
    cand[0].record_index = tc;
    cand[0].current_mode = md;
    case (plane_r)
      PLANE_XZ: begin
        cand[0].coord_a = tip[0];
        cand[0].coord_b = tip[2];
      end
      PLANE_YZ: begin
        cand[0].coord_a = tip[1];
        cand[0].coord_b = tip[2];
      end
      default: begin
        cand[0].coord_a = tip[0];
        cand[0].coord_b = tip[1];
      end
    endcase
    if (trace_hit) begin
      tc = tc + 32'd1;
      for (int i = 0; i < 3; i++) lpos_nxt[i] = tip[i];
    end

    // host command
    cand[1].current_mode = md;
    case (in_r.host_cmd)
      CMD_SAMPLE: begin
        cand_v[1] = 1'b1;
        cand[1].record_kind  = KIND_POINT;
        cand[1].record_index = pc;
        cand[1].coord_a      = tip[0];
        cand[1].coord_b      = tip[1];
        cand[1].coord_c      = tip[2];
        pc = pc + 32'd1;
      end
      CMD_TOGGLE: begin
        cand_v[1] = 1'b1;
        tr = ~tr;
        if (tr) begin
          cand[1].record_kind = KIND_TRACE_START;
          tc = '0;
          for (int i = 0; i < 3; i++) lpos_nxt[i] = tip[i];
        end else begin
          cand[1].record_kind = KIND_TRACE_STOP;
        end
      end
      CMD_CLEAR: begin
        cand_v[1] = 1'b1;
        cand[1].record_kind = KIND_COUNTERS_RESET;
        pc = '0;
        tc = '0;
      end
      default: ;
    endcase

    // sample button
    cand_v[2] = hit[BTN_SAMPLE];
    cand[2].record_kind  = KIND_POINT;
    cand[2].record_index = pc;
    cand[2].coord_a      = tip[0];
    cand[2].coord_b      = tip[1];
    cand[2].coord_c      = tip[2];
    cand[2].current_mode = md;
    if (hit[BTN_SAMPLE]) pc = pc + 32'd1;

    // mode button, cycles measure -> trace -> digitize
    if (hit[BTN_MODE]) begin
      case (md)
        MODE_MEASURE: md = MODE_TRACING;
        MODE_TRACING: md = MODE_DIGITIZE;
        default:      md = MODE_MEASURE;
      endcase
    end
    cand_v[3] = hit[BTN_MODE];
    cand[3].record_kind  = KIND_MODE_CHANGE;
    cand[3].current_mode = md;

    // foot button: toggle trace in trace mode, else sample
    cand_v[4] = hit[BTN_FOOT];
    cand[4].current_mode = md;
    if (md == MODE_TRACING) begin
      if (tr) begin
        cand[4].record_kind = KIND_TRACE_STOP;
      end else begin
        cand[4].record_kind = KIND_TRACE_START;
      end
      if (hit[BTN_FOOT]) begin
        tr = ~tr;
        if (tr) begin
          tc = '0;
          for (int i = 0; i < 3; i++) lpos_nxt[i] = tip[i];
        end
      end
    end else begin
      cand[4].record_kind  = KIND_POINT;
      cand[4].record_index = pc;
      cand[4].coord_a      = tip[0];
      cand[4].coord_b      = tip[1];
      cand[4].coord_c      = tip[2];
      if (hit[BTN_FOOT]) pc = pc + 32'd1;
    end

    pcount_nxt  = pc;
    tcount_nxt  = tc;
    tracing_nxt = tr;
    mode_nxt    = md;

    // pack the present records in order and mark the last one
    n_rec = '0;
    for (int i = 0; i < MAX_REC; i++) batch[i] = '0;
    for (int i = 0; i < MAX_REC; i++) begin
      if (cand_v[i]) begin
        batch[n_rec] = cand[i];
        n_rec = n_rec + REC_CNT_W'(1);
      end
    end
    if (n_rec != '0) batch[n_rec - REC_CNT_W'(1)].last_of_tick = 1'b1;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
  end

  // tick state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_MEASURE;
      tracing_r <= 1'b0;
      pcount_r  <= '0;
      tcount_r  <= '0;
      for (int i = 0; i < 3; i++) lpos_r[i] <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        btn_prev_r[i] <= 1'b1;
        press_r[i]    <= '0;
      end
    end else if (fire) begin
      mode_r    <= mode_nxt;
      tracing_r <= tracing_nxt;
      pcount_r  <= pcount_nxt;
      tcount_r  <= tcount_nxt;
      for (int i = 0; i < 3; i++) lpos_r[i] <= lpos_nxt[i];
      for (int i = 0; i < NUM_BTN; i++) begin
        btn_prev_r[i] <= btn_prev_nxt[i];
        press_r[i]    <= press_nxt[i];
      end
    end
  end

  // record buffer: load a batch, or shift out one record per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (fire) begin
      rem_r <= n_rec;
    end else if (pop) begin
      rem_r <= rem_r - REC_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < MAX_REC; i++) rec_r[i] <= batch[i];
    end else if (pop) begin
      for (int i = 0; i < MAX_REC - 1; i++) rec_r[i] <= rec_r[i+1];
    end
  end

  // checks
  assign chk_last_slot  = out_valid && (rem_r == REC_CNT_W'(1));
  assign chk_plain_kind = out_valid && (out_data.record_kind != KIND_POINT) &&
                          (out_data.record_kind != KIND_TRACE_POINT);

  `PPCC_ASSERT_IMP(a_last_marks_end, chk_last_slot, out_data.last_of_tick, "no last mark")
  `PPCC_ASSERT_IMP(a_rem_bound, 1'b1, rem_r <= REC_CNT_W'(MAX_REC), "buffer over depth")
  `PPCC_ASSERT_IMP(a_index_zero, chk_plain_kind, out_data.record_index == '0, "stray index")

endmodule
